// ----- design/rwct_pkg.sv -----
// rwct_pkg: shared types and constants of the textured wall column texel block.
// Holds the request/response transaction structs, CSR indexes, slot codes and
// the fixed constants of the cosine pipeline. No dependencies.
package rwct_pkg;

   // Angles in sixteenths of a degree
   localparam logic [12:0] FULL_TURN    = 13'd5760;
   localparam logic [12:0] HALF_TURN    = 13'd2880;
   localparam logic [12:0] QUARTER_TURN = 13'd1440;

   // CSR indexes
   localparam logic [2:0] CSR_PLAYER_ANGLE   = 3'd0;
   localparam logic [2:0] CSR_PLAYER_X       = 3'd1;
   localparam logic [2:0] CSR_PLAYER_Y       = 3'd2;
   localparam logic [2:0] CSR_PROJECTION     = 3'd3;
   localparam logic [2:0] CSR_ART_TEXTURES   = 3'd4;

   // Texture slot codes
   localparam logic [3:0] SLOT_S   = 4'd0;
   localparam logic [3:0] SLOT_N   = 4'd1;
   localparam logic [3:0] SLOT_W   = 4'd2;
   localparam logic [3:0] SLOT_E   = 4'd3;
   localparam logic [3:0] SLOT_ART = 4'd4;
   localparam logic [3:0] SLOT_ERR = 4'd8;

   // Angle to Q28 radians: d*PI_Q28/2880 = d*X_MUL_INT + d*X_MUL_FRAC/2880
   localparam logic [18:0] X_MUL_INT  = 19'd292817;
   localparam logic [10:0] X_MUL_FRAC = 11'd1897;
   localparam logic [11:0] X_DIV      = 12'd2880;
   localparam logic [10:0] X_RECIP    = 11'd1456;   // floor(2^22 / 2880)

   localparam logic [28:0] ONE_Q28 = 29'h1000_0000;

   // Cosine series steps, each divides by a constant via a Q30 reciprocal
   localparam int COS_STEPS = 5;
   localparam int unsigned RECIP_ONE = 32'h4000_0000;
   localparam int unsigned COS_DIV [COS_STEPS] = '{90, 56, 30, 12, 2};
   localparam int unsigned COS_RECIP [COS_STEPS] = '{
      RECIP_ONE / 90, RECIP_ONE / 56, RECIP_ONE / 30, RECIP_ONE / 12, RECIP_ONE / 2};

   // Register stages of the cosine unit: four front stages, three per step
   localparam int COS_LAT = 4 + 3 * COS_STEPS;

   typedef struct packed {
      logic [12:0] ray_angle;
      logic [23:0] horiz_hit_x;
      logic [23:0] horiz_hit_y;
      logic [23:0] vert_hit_x;
      logic [23:0] vert_hit_y;
      logic [23:0] horiz_distance;
      logic [23:0] vert_distance;
      logic [9:0]  screen_column;
      logic [9:0]  screen_row;
   } req_type;

   typedef struct packed {
      logic [9:0]  out_column;
      logic [9:0]  out_row;
      logic        in_wall;
      logic [3:0]  texture_slot;
      logic [11:0] texel_index;
      logic [15:0] wall_span;
   } rsp_type;

endpackage

// ----- design/rwct_cos.sv -----
// rwct_cos: pipelined Q16 cosine of an angle below a quarter turn.
// Angle scaling, squaring, then five series steps of three stages each.
// Depends on rwct_pkg.
module rwct_cos (
   input  logic        clock,
   input  logic        adv,
   input  logic [10:0] d_in,
   output logic [16:0] c_out
);

   localparam int STEPS = rwct_pkg::COS_STEPS;

   // front stages
   logic [28:0] pa_ff, pa2_ff, pa_in;
   logic [21:0] pb_ff, pb2_ff, pb_in;
   logic [9:0]  qx_ff, qx_in;
   logic [32:0] qx_prod;
   logic [21:0] xr;
   logic [28:0] x_ff, x_in;
   logic [57:0] xsq;
   logic [29:0] x2_ff, x2_in;

   // series step registers
   logic [29:0] na_ff  [STEPS];
   logic [29:0] x2a_ff [STEPS];
   logic [29:0] qb_ff  [STEPS];
   logic [29:0] nb_ff  [STEPS];
   logic [29:0] x2b_ff [STEPS];
   logic [28:0] t_ff   [STEPS];
   logic [29:0] x2o_ff [STEPS];

   logic [28:0] t_link  [STEPS];
   logic [29:0] x2_link [STEPS];
   logic [58:0] sprod   [STEPS];
   logic [29:0] n_in    [STEPS];
   logic [59:0] qprod   [STEPS];
   logic [29:0] qb_in   [STEPS];
   logic [29:0] sr      [STEPS];
   logic [29:0] sp      [STEPS];
   logic [28:0] t_in    [STEPS];

   // angle to radians, exact floor via split constant and reciprocal
   always_comb begin
      pa_in   = 29'(d_in) * 29'(rwct_pkg::X_MUL_INT);
      pb_in   = 22'(d_in) * 22'(rwct_pkg::X_MUL_FRAC);
      qx_prod = 33'(pb_ff) * 33'(rwct_pkg::X_RECIP);
      qx_in   = qx_prod[31:22];
      xr      = pb2_ff - 22'(qx_ff) * 22'(rwct_pkg::X_DIV);
      x_in    = pa2_ff + 29'(qx_ff) + ((xr >= 22'(rwct_pkg::X_DIV)) ? 29'd1 : 29'd0);
      xsq     = 58'(x_ff) * 58'(x_ff);
      x2_in   = xsq[57:28];
   end

   // series steps: t = 1 - ((x2*t)>>28)/k
   always_comb begin
      for (int k = 0; k < STEPS; k++) begin
         if (k == 0) begin
            t_link[k]  = rwct_pkg::ONE_Q28;
            x2_link[k] = x2_ff;
         end else begin
            t_link[k]  = t_ff[k-1];
            x2_link[k] = x2o_ff[k-1];
         end
         sprod[k] = 59'(x2_link[k]) * 59'(t_link[k]);
         n_in[k]  = sprod[k][57:28];
         qprod[k] = 60'(na_ff[k]) * 60'(rwct_pkg::COS_RECIP[k]);
         qb_in[k] = qprod[k][59:30];
         sr[k]    = nb_ff[k] - qb_ff[k] * 30'(rwct_pkg::COS_DIV[k]);
         sp[k]    = qb_ff[k] + ((sr[k] >= 30'(rwct_pkg::COS_DIV[k])) ? 30'd1 : 30'd0);
         t_in[k]  = (sp[k] >= 30'(rwct_pkg::ONE_Q28)) ? 29'd0
                    : 29'(30'(rwct_pkg::ONE_Q28) - sp[k]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pa_ff  <= pa_in;
         pb_ff  <= pb_in;
         pa2_ff <= pa_ff;
         pb2_ff <= pb_ff;
         qx_ff  <= qx_in;
         x_ff   <= x_in;
         x2_ff  <= x2_in;
         for (int k = 0; k < STEPS; k++) begin
            na_ff[k]  <= n_in[k];
            x2a_ff[k] <= x2_link[k];
            qb_ff[k]  <= qb_in[k];
            nb_ff[k]  <= na_ff[k];
            x2b_ff[k] <= x2a_ff[k];
            t_ff[k]   <= t_in[k];
            x2o_ff[k] <= x2b_ff[k];
         end
      end
   end

   assign c_out = t_ff[STEPS-1][28:12];

endmodule

// ----- design/rwct_div.sv -----
// rwct_div: pipelined restoring divider, one quotient bit per stage.
// Quotient saturates to all ones when it would not fit (also for a zero divisor).
// Depends on nothing.
module rwct_div #(
   parameter int NUM_W = 51,
   parameter int DEN_W = 48,
   parameter int Q_W   = 16
) (
   input  logic             clock,
   input  logic             adv,
   input  logic [NUM_W-1:0] num_in,
   input  logic [DEN_W-1:0] den_in,
   output logic [Q_W-1:0]   q_out
);

   localparam int W = ((NUM_W > DEN_W + Q_W) ? NUM_W : DEN_W + Q_W) + 1;

   logic [W-1:0]     rem_ff [Q_W];
   logic [DEN_W-1:0] den_ff [Q_W];
   logic [Q_W-1:0]   quo_ff [Q_W];
   logic [Q_W:0]     sat_ff;

   logic [W-1:0]     shd    [Q_W];
   logic [Q_W-1:0]   ge;
   logic [W-1:0]     rem_nx [Q_W];
   logic             sat_in;

   // overflow test, then one trial subtraction per stage
   always_comb begin
      sat_in = W'(num_in) >= (W'(den_in) << Q_W);
      for (int j = 0; j < Q_W; j++) begin
         shd[j]    = W'(den_ff[j]) << (Q_W - 1 - j);
         ge[j]     = rem_ff[j] >= shd[j];
         rem_nx[j] = ge[j] ? (rem_ff[j] - shd[j]) : rem_ff[j];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= W'(num_in);
         den_ff[0] <= den_in;
         sat_ff[0] <= sat_in;
         quo_ff[0] <= Q_W'(ge[0]);
         for (int j = 1; j < Q_W; j++) begin
            rem_ff[j] <= rem_nx[j-1];
            den_ff[j] <= den_ff[j-1];
            quo_ff[j] <= (quo_ff[j-1] << 1) | Q_W'(ge[j]);
         end
         for (int j = 1; j <= Q_W; j++) begin
            sat_ff[j] <= sat_ff[j-1];
         end
      end
   end

   assign q_out = sat_ff[Q_W] ? {Q_W{1'b1}} : quo_ff[Q_W-1];

endmodule

// ----- design/raycast_wall_column_texel.sv -----
// raycast_wall_column_texel: top level of the textured wall column texel pipeline.
// Instantiates rwct_cos and two rwct_div; uses rwct_pkg.
//
//  channel | direction | handshake          | payload
//  req     | in        | req_valid/req_ready | req_data  (rwct_pkg::req_type)
//  rsp     | out       | rsp_valid/rsp_ready | rsp_data  (rwct_pkg::rsp_type)
//  csr     | in        | csr_we             | csr_index, csr_wdata
//
// One transaction per cycle while the output buffer is not full. The pipeline
// depth is set by the cosine unit (19 stages) and the two pipelined dividers
// (17 and 7 stages). Reset is synchronous, active high, and clears valid bits,
// the output buffer and the CSRs. Results land in a two-entry output buffer; the
// whole pipeline holds only while that buffer is full, so nothing is lost.
module raycast_wall_column_texel #(
   parameter int SCREEN_HEIGHT  = 512,
   parameter int WALL_SCALE     = 64,
   parameter int HEIGHT_DIVISOR = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rwct_pkg::req_type   req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output rwct_pkg::rsp_type   rsp_data,
   input  logic                csr_we,
   input  logic [2:0]          csr_index,
   input  logic [23:0]         csr_wdata
);

   localparam int LC     = rwct_pkg::COS_LAT;
   localparam int NUMA_W = 24 + $clog2(WALL_SCALE + 1);
   localparam int NUM_W  = NUMA_W + 16;
   localparam int DEN_W  = 41 + $clog2(HEIGHT_DIVISOR + 1);
   localparam int L1     = 16 + 1;
   localparam int L2     = 6 + 1;

   typedef struct packed {
      logic        vld;
      logic        behind;
      logic        quarter;
      logic [23:0] hit_dist;
      logic [9:0]  col;
      logic [9:0]  row;
      logic [5:0]  texcol;
      logic [3:0]  slot;
   } front_type;

   typedef struct packed {
      logic        vld;
      logic        behind;
      logic [9:0]  col;
      logic [9:0]  row;
      logic [5:0]  texcol;
      logic [3:0]  slot;
   } mid_type;

   typedef struct packed {
      logic        vld;
      logic        in_wall;
      logic [15:0] span;
      logic [9:0]  col;
      logic [9:0]  row;
      logic [5:0]  texcol;
      logic [3:0]  slot;
   } back_type;

   // CSRs
   logic [12:0] player_angle_ff;
   logic [23:0] player_x_ff, player_y_ff, proj_ff;
   logic        art_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         player_angle_ff <= '0;
         player_x_ff     <= '0;
         player_y_ff     <= '0;
         proj_ff         <= '0;
         art_ff          <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            rwct_pkg::CSR_PLAYER_ANGLE: player_angle_ff <= csr_wdata[12:0];
            rwct_pkg::CSR_PLAYER_X:     player_x_ff     <= csr_wdata;
            rwct_pkg::CSR_PLAYER_Y:     player_y_ff     <= csr_wdata;
            rwct_pkg::CSR_PROJECTION:   proj_ff         <= csr_wdata;
            rwct_pkg::CSR_ART_TEXTURES: art_ff          <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // pipeline registers
   logic              adv;
   front_type         s1_ff, s1_in;
   logic [10:0]       ang_ff, ang_in;
   front_type         dla_ff [LC];
   mid_type           d1_ff, d1_in, d2_ff;
   logic [40:0]       den0_ff, den0_in;
   logic [NUMA_W-1:0] numa_ff, numa_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [NUM_W-1:0]  num_ff;
   mid_type           dlb_ff [L1];
   back_type          e1_ff, e1_in;
   logic [22:0]       num2_ff, num2_in;
   logic [15:0]       den2_ff, den2_in;
   back_type          dlc_ff [L2];

   // stage 1: angle difference, hit choice, texture side and column
   logic [12:0] ray_m, pa_m, dd;
   logic [11:0] dfold;
   logic        hnone, vnone, vert;
   logic [23:0] hit_x, hit_y;
   logic [5:0]  tc;
   logic [3:0]  slot;

   always_comb begin
      ray_m = (req_data.ray_angle >= rwct_pkg::FULL_TURN)
              ? req_data.ray_angle - rwct_pkg::FULL_TURN : req_data.ray_angle;
      pa_m  = (player_angle_ff >= rwct_pkg::FULL_TURN)
              ? player_angle_ff - rwct_pkg::FULL_TURN : player_angle_ff;
      dd    = (ray_m >= pa_m) ? ray_m - pa_m : rwct_pkg::FULL_TURN - (pa_m - ray_m);
      dfold = (dd > rwct_pkg::HALF_TURN) ? 12'(rwct_pkg::FULL_TURN - dd) : dd[11:0];

      hnone = (req_data.horiz_hit_x == '0) && (req_data.horiz_hit_y == '0);
      vnone = (req_data.vert_hit_x == '0) && (req_data.vert_hit_y == '0);
      priority if (hnone) vert = 1'b1;
      else if (vnone)     vert = 1'b0;
      else                vert = req_data.horiz_distance > req_data.vert_distance;

      hit_x = vert ? req_data.vert_hit_x : req_data.horiz_hit_x;
      hit_y = vert ? req_data.vert_hit_y : req_data.horiz_hit_y;

      if (vert) begin
         tc = hit_y[13:8];
         priority if (player_x_ff > hit_x) begin
            tc   = ~tc;
            slot = rwct_pkg::SLOT_W;
         end else if (player_x_ff < hit_x) begin
            slot = rwct_pkg::SLOT_E;
         end else begin
            slot = rwct_pkg::SLOT_ERR;
         end
      end else begin
         tc = hit_x[13:8];
         priority if (player_y_ff < hit_y) begin
            tc   = ~tc;
            slot = rwct_pkg::SLOT_S;
         end else if (player_y_ff > hit_y) begin
            slot = rwct_pkg::SLOT_N;
         end else begin
            slot = rwct_pkg::SLOT_ERR;
         end
      end
      if (slot != rwct_pkg::SLOT_ERR && art_ff) slot = slot | rwct_pkg::SLOT_ART;

      s1_in.vld      = req_valid && req_ready;
      s1_in.behind   = dfold > 12'(rwct_pkg::QUARTER_TURN);
      s1_in.quarter  = dfold == 12'(rwct_pkg::QUARTER_TURN);
      s1_in.hit_dist = vert ? req_data.vert_distance : req_data.horiz_distance;
      s1_in.col      = req_data.screen_column;
      s1_in.row      = req_data.screen_row;
      s1_in.texcol   = tc;
      s1_in.slot     = slot;
      ang_in         = dfold[10:0];
   end

   // cosine unit
   logic [16:0] cos_q16;

   rwct_cos u_cos (
      .clock (clock),
      .adv   (adv),
      .d_in  (ang_ff),
      .c_out (cos_q16)
   );

   // stages D1/D2: denominator and numerator of the height
   front_type cos_side;

   always_comb begin
      cos_side      = dla_ff[LC-1];
      den0_in       = 41'(cos_side.hit_dist) * 41'(cos_side.quarter ? 17'd0 : cos_q16);
      numa_in       = NUMA_W'(proj_ff) * NUMA_W'(WALL_SCALE);
      d1_in.vld     = cos_side.vld;
      d1_in.behind  = cos_side.behind;
      d1_in.col     = cos_side.col;
      d1_in.row     = cos_side.row;
      d1_in.texcol  = cos_side.texcol;
      d1_in.slot    = cos_side.slot;
      den_in        = DEN_W'(den0_ff) * DEN_W'(HEIGHT_DIVISOR);
   end

   // wall height divider
   logic [15:0] h_q;

   rwct_div #(.NUM_W(NUM_W), .DEN_W(DEN_W), .Q_W(16)) u_div_h (
      .clock  (clock),
      .adv    (adv),
      .num_in (num_ff),
      .den_in (den_ff),
      .q_out  (h_q)
   );

   // stage E1: wall span and texel row numerator
   mid_type     hs;
   logic [15:0] h;
   logic [16:0] sh, hw, span_start, span_end, rw, a;

   always_comb begin
      hs          = dlb_ff[L1-1];
      h           = hs.behind ? 16'd0 : h_q;
      sh          = 17'(SCREEN_HEIGHT);
      hw          = 17'(h);
      span_start  = (sh >= hw) ? ((sh - hw) >> 1) : 17'd0;
      span_end    = (sh + hw) >> 1;
      rw          = 17'(hs.row);
      a           = span_end - rw - 17'd1;
      e1_in.vld     = hs.vld;
      e1_in.in_wall = (h != 16'd0) && (rw >= span_start) && (rw < span_end) && (rw < sh);
      e1_in.span    = h;
      e1_in.col     = hs.col;
      e1_in.row     = hs.row;
      e1_in.texcol  = hs.texcol;
      e1_in.slot    = hs.slot;
      num2_in       = {a, 6'b0};
      den2_in       = h;
   end

   // texel row divider, saturates at 63
   logic [5:0] trow;

   rwct_div #(.NUM_W(23), .DEN_W(16), .Q_W(6)) u_div_t (
      .clock  (clock),
      .adv    (adv),
      .num_in (num2_ff),
      .den_in (den2_ff),
      .q_out  (trow)
   );

   // pipeline advance, valid bits cleared on reset
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ff.vld <= 1'b0;
         d1_ff.vld <= 1'b0;
         d2_ff.vld <= 1'b0;
         e1_ff.vld <= 1'b0;
         for (int i = 0; i < LC; i++) dla_ff[i].vld <= 1'b0;
         for (int i = 0; i < L1; i++) dlb_ff[i].vld <= 1'b0;
         for (int i = 0; i < L2; i++) dlc_ff[i].vld <= 1'b0;
      end else if (adv) begin
         s1_ff     <= s1_in;
         ang_ff    <= ang_in;
         dla_ff[0] <= s1_ff;
         for (int i = 1; i < LC; i++) dla_ff[i] <= dla_ff[i-1];
         d1_ff     <= d1_in;
         den0_ff   <= den0_in;
         numa_ff   <= numa_in;
         d2_ff     <= d1_ff;
         den_ff    <= den_in;
         num_ff    <= {numa_ff, 16'd0};
         dlb_ff[0] <= d2_ff;
         for (int i = 1; i < L1; i++) dlb_ff[i] <= dlb_ff[i-1];
         e1_ff     <= e1_in;
         num2_ff   <= num2_in;
         den2_ff   <= den2_in;
         dlc_ff[0] <= e1_ff;
         for (int i = 1; i < L2; i++) dlc_ff[i] <= dlc_ff[i-1];
      end
   end

   // result assembly
   back_type          fin;
   rwct_pkg::rsp_type res;

   always_comb begin
      fin              = dlc_ff[L2-1];
      res.out_column   = fin.col;
      res.out_row      = fin.row;
      res.in_wall      = fin.in_wall;
      res.texture_slot = fin.slot;
      res.texel_index  = fin.in_wall ? {trow, fin.texcol} : 12'd0;
      res.wall_span    = fin.span;
   end

   // two-entry output buffer
   rwct_pkg::rsp_type head_ff, spare_ff;
   logic [1:0]        cnt_ff;
   logic              push, pop;

   assign adv       = cnt_ff != 2'd2;
   assign req_ready = adv;
   assign push      = adv && fin.vld;
   assign rsp_valid = cnt_ff != 2'd0;
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = head_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         unique case (cnt_ff)
            2'd0: begin
               if (push) begin
                  head_ff <= res;
                  cnt_ff  <= 2'd1;
               end
            end
            2'd1: begin
               if (push && pop) begin
                  head_ff <= res;
               end else if (push) begin
                  spare_ff <= res;
                  cnt_ff   <= 2'd2;
               end else if (pop) begin
                  cnt_ff <= 2'd0;
               end
            end
            2'd2: begin
               if (pop) begin
                  head_ff <= spare_ff;
                  cnt_ff  <= 2'd1;
               end
            end
            default: cnt_ff <= 2'd0;
         endcase
      end
   end

   // checks
   a_wall_has_span: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.in_wall |-> rsp_data.wall_span != 16'd0)
      else $error("in_wall set with zero wall span");

   a_texel_outside: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.in_wall |-> rsp_data.texel_index == 12'd0)
      else $error("texel index nonzero outside the wall");

   a_slot_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_data.texture_slot <= (rwct_pkg::SLOT_ART | rwct_pkg::SLOT_E)
                 || rsp_data.texture_slot == rwct_pkg::SLOT_ERR)
      else $error("texture slot out of range");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 && !rsp_ready |=> !req_ready)
      else $error("input accepted while output buffer stayed full");

endmodule

// ----- dv/tb_top.sv -----
// tb_top: self-checking testbench for raycast_wall_column_texel.
// Drives pixel requests over valid/ready, predicts each response in SV (or
// uses the table's), compares field by field; needs only rwct_pkg and RTL.
`timescale 1ns / 100ps

module tb_top;

   localparam int unsigned SCREEN_ROWS = 512;
   localparam int unsigned TEX_SIZE    = 64;
   localparam int unsigned SCALE       = 64;
   localparam int unsigned HDIV        = 1;
   localparam longint unsigned PI_Q28_RAD = 64'd843314857;
   localparam longint unsigned UNITY_Q28  = 64'd1 << 28;
   localparam int DRAIN_CYCLES = 60;
   localparam int HOLD_CYCLES  = 400;
   localparam int BLOCKS       = 5;
   localparam int BLOCK_ITEMS  = 126;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   rwct_pkg::req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rwct_pkg::rsp_type rsp_data;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = rwct_pkg::CSR_PLAYER_ANGLE;
   logic [23:0] csr_wdata = '0;

   // Mirror of the CSRs as the block should see them
   logic [12:0] heading_q;
   logic [23:0] viewer_x_q, viewer_y_q, proj_dist_q;
   logic art_set_q;

   rwct_pkg::rsp_type texel_q[$];
   int errors = 0;
   int items_sent = 0;
   int checked = 0;
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   bit typed_next = 1'b0;
   rwct_pkg::rsp_type typed_rsp;

   raycast_wall_column_texel dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // Expected pixel response from the request and the current CSR values
   function automatic rwct_pkg::rsp_type wall_texel(rwct_pkg::req_type r);
      longint unsigned series_div[5] = '{90, 56, 30, 12, 2};
      longint unsigned ray, head, d, c, h, num, den, hit_dist, px, py, texcol, trow;
      longint unsigned x, x2, t, p;
      longint s, e, rw;
      logic vert;
      logic [3:0] slot;
      rwct_pkg::rsp_type o;
      ray  = r.ray_angle % rwct_pkg::FULL_TURN;
      head = heading_q % rwct_pkg::FULL_TURN;
      if (r.horiz_hit_x == 0 && r.horiz_hit_y == 0) vert = 1'b1;
      else if (r.vert_hit_x == 0 && r.vert_hit_y == 0) vert = 1'b0;
      else vert = r.horiz_distance > r.vert_distance;
      px   = vert ? r.vert_hit_x : r.horiz_hit_x;
      py   = vert ? r.vert_hit_y : r.horiz_hit_y;
      hit_dist = vert ? r.vert_distance : r.horiz_distance;

      // fold the angle off heading into [0, half turn]
      d = (ray + rwct_pkg::FULL_TURN - head) % rwct_pkg::FULL_TURN;
      if (d > rwct_pkg::HALF_TURN) d = rwct_pkg::FULL_TURN - d;
      if (d > rwct_pkg::QUARTER_TURN) begin
         h = 0;
      end else begin
         if (d == rwct_pkg::QUARTER_TURN) begin
            c = 0;
         end else begin
            x  = d * PI_Q28_RAD / rwct_pkg::HALF_TURN;
            x2 = (x * x) >> 28;
            t  = UNITY_Q28;
            for (int i = 0; i < 5; i++) begin
               p = ((x2 * t) >> 28) / series_div[i];
               t = (p >= UNITY_Q28) ? 0 : UNITY_Q28 - p;
            end
            c = t >> 12;
         end
         den = hit_dist * c * HDIV;
         if (den == 0) begin
            h = 65535;
         end else begin
            num = (longint'(SCALE) * proj_dist_q) << 16;
            h = num / den;
            if (h > 65535) h = 65535;
         end
      end

      // texture column, mirroring and face
      if (vert) begin
         texcol = (py >> 8) % TEX_SIZE;
         if (viewer_x_q > px) begin
            texcol = TEX_SIZE - 1 - texcol;
            slot = rwct_pkg::SLOT_W;
         end else if (viewer_x_q < px) slot = rwct_pkg::SLOT_E;
         else slot = rwct_pkg::SLOT_ERR;
      end else begin
         texcol = (px >> 8) % TEX_SIZE;
         if (viewer_y_q < py) begin
            texcol = TEX_SIZE - 1 - texcol;
            slot = rwct_pkg::SLOT_S;
         end else if (viewer_y_q > py) slot = rwct_pkg::SLOT_N;
         else slot = rwct_pkg::SLOT_ERR;
      end
      if (slot != rwct_pkg::SLOT_ERR && art_set_q) slot = slot + rwct_pkg::SLOT_ART;

      o = '0;
      o.out_column = r.screen_column;
      o.out_row = r.screen_row;
      o.texture_slot = slot;
      o.wall_span = h[15:0];
      if (h > 0) begin
         s  = (longint'(SCREEN_ROWS) - longint'(h)) / 2;
         e  = (longint'(SCREEN_ROWS) + longint'(h)) / 2;
         rw = r.screen_row;
         if (s < 0) s = 0;
         if (rw >= s && rw < e && rw < SCREEN_ROWS) begin
            trow = longint'(e - rw - 1) * TEX_SIZE / h;
            if (trow > TEX_SIZE - 1) trow = TEX_SIZE - 1;
            o.in_wall = 1'b1;
            o.texel_index = 12'(trow * TEX_SIZE + texcol);
         end
      end
      return o;
   endfunction

   // Scoreboard: predict on request transaction, check on response transaction
   always @(posedge clock) begin
      rwct_pkg::rsp_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            texel_q.push_back(typed_next ? typed_rsp : wall_texel(req_data));
            items_sent++;
         end
         if (rsp_valid && rsp_ready) begin
            if (texel_q.size() == 0) begin
               errors++;
               $display("%0t: response with nothing expected, actual %p", $realtime, rsp_data);
            end else begin
               want = texel_q.pop_front();
               checked++;
               if (rsp_data.out_column !== want.out_column ||
                   rsp_data.out_row !== want.out_row ||
                   rsp_data.in_wall !== want.in_wall ||
                   rsp_data.texture_slot !== want.texture_slot ||
                   rsp_data.texel_index !== want.texel_index ||
                   rsp_data.wall_span !== want.wall_span) begin
                  errors++;
                  $display("%0t: mismatch expected %p actual %p", $realtime, want, rsp_data);
               end
            end
         end
      end
   end

   // Receiver: random back-pressure plus one long hold-off
   always @(posedge clock) begin
      int hold_cnt;
      if (hold_go && !hold_done) begin
         rsp_ready <= 1'b0;
         hold_cnt++;
         if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic csr_write(logic [2:0] idx, logic [23:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         rwct_pkg::CSR_PLAYER_ANGLE: heading_q = val[12:0];
         rwct_pkg::CSR_PLAYER_X:     viewer_x_q = val;
         rwct_pkg::CSR_PLAYER_Y:     viewer_y_q = val;
         rwct_pkg::CSR_PROJECTION:   proj_dist_q = val;
         rwct_pkg::CSR_ART_TEXTURES: art_set_q = val[0];
         default: ;
      endcase
   endtask

   task automatic load_view(logic [12:0] ang, logic [23:0] vx, logic [23:0] vy,
                            logic [23:0] pd, logic art);
      csr_write(rwct_pkg::CSR_PLAYER_ANGLE, {11'd0, ang});
      csr_write(rwct_pkg::CSR_PLAYER_X, vx);
      csr_write(rwct_pkg::CSR_PLAYER_Y, vy);
      csr_write(rwct_pkg::CSR_PROJECTION, pd);
      csr_write(rwct_pkg::CSR_ART_TEXTURES, {23'd0, art});
   endtask

   // Drive one request; valid stays up until the transaction completes
   task automatic push_pixel(rwct_pkg::req_type r, bit typed, rwct_pkg::rsp_type typed_val);
      if (send_idle_pct > 0) begin
         while ($urandom_range(99) < send_idle_pct) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data <= r;
      typed_next <= typed;
      typed_rsp <= typed_val;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic drain;
      req_valid <= 1'b0;
      while (texel_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic [23:0] rand_dist();
      int sel;
      sel = $urandom_range(99);
      if (sel < 5) return 24'd0;
      if (sel < 15) return 24'hFFFFFF;
      return 24'($urandom() & ((32'd1 << $urandom_range(8, 24)) - 32'd1));
   endfunction

   // Random request shaped around the current view
   function automatic rwct_pkg::req_type rand_pixel();
      rwct_pkg::req_type r;
      r.ray_angle = ($urandom_range(9) == 0) ? 13'($urandom_range(8191))
                  : 13'((heading_q % rwct_pkg::FULL_TURN + rwct_pkg::FULL_TURN
                         + $urandom_range(3200) - 1600) % rwct_pkg::FULL_TURN);
      r.horiz_hit_x = 24'($urandom());
      r.horiz_hit_y = ($urandom_range(4) == 0) ? viewer_y_q : 24'($urandom());
      r.vert_hit_x  = ($urandom_range(4) == 0) ? viewer_x_q : 24'($urandom());
      r.vert_hit_y  = 24'($urandom());
      if ($urandom_range(9) == 0) begin
         r.horiz_hit_x = 0;
         r.horiz_hit_y = 0;
      end
      if ($urandom_range(9) == 0) begin
         r.vert_hit_x = 0;
         r.vert_hit_y = 0;
      end
      r.horiz_distance = rand_dist();
      r.vert_distance = ($urandom_range(9) == 0) ? r.horiz_distance : rand_dist();
      r.screen_column = 10'($urandom());
      r.screen_row = ($urandom_range(3) == 0) ? 10'($urandom()) : 10'($urandom_range(511));
      return r;
   endfunction

   typedef struct {
      rwct_pkg::req_type req;
      bit typed;
      rwct_pkg::rsp_type want;
   } pixel_row_type;

   pixel_row_type pixel_table[$];

   // Directed table: extremes, hit choice, fold, saturation, error face
   task automatic build_table;
      rwct_pkg::req_type r;
      // both hits none, zero distance: saturated span, error face
      r = '0; r.screen_column = 10'd1023; r.screen_row = 10'd1023;
      pixel_table.push_back('{r, 1'b1,
         '{10'd1023, 10'd1023, 1'b0, rwct_pkg::SLOT_ERR, 12'd0, 16'hFFFF}});
      // ray behind the viewer: no wall
      r = '0; r.ray_angle = rwct_pkg::HALF_TURN;
      r.horiz_hit_x = 24'h100; r.horiz_hit_y = 24'h100;
      r.horiz_distance = 24'h400; r.screen_row = 10'd256;
      pixel_table.push_back('{r, 1'b1,
         '{10'd0, 10'd256, 1'b0, rwct_pkg::SLOT_S, 12'd0, 16'd0}});
      // exactly a quarter turn off: corrected distance zero, row off screen
      r.ray_angle = rwct_pkg::QUARTER_TURN; r.screen_row = 10'd600; r.screen_column = 10'd5;
      pixel_table.push_back('{r, 1'b1,
         '{10'd5, 10'd600, 1'b0, rwct_pkg::SLOT_S, 12'd0, 16'hFFFF}});
      // remaining rows are predicted
      r = '0; r.ray_angle = 13'h1FFF; r.horiz_hit_x = 24'hFFFFFF; r.horiz_hit_y = 24'hFFFFFF;
      r.vert_hit_x = 24'hFFFFFF; r.vert_hit_y = 24'hFFFFFF;
      r.horiz_distance = 24'hFFFFFF; r.vert_distance = 24'hFFFFFF;
      r.screen_column = 10'h3FF; r.screen_row = 10'h3FF;
      pixel_table.push_back('{r, 1'b0, '0});
      for (int i = 0; i < 16; i++) begin
         r = '0;
         r.ray_angle = (i < 8) ? 13'(i * 720) : 13'(5760 + i * 40);
         r.horiz_hit_x = 24'(24'h012345 + i * 24'h4100);
         r.horiz_hit_y = (i % 4 == 0) ? 24'h0 : 24'(24'h020000 - i * 24'h3300);
         r.vert_hit_x  = (i % 3 == 0) ? 24'h0 : 24'(24'h010000 + i * 24'h2200);
         r.vert_hit_y  = (i % 5 == 0) ? 24'h0 : 24'(24'h00FF00 + i * 24'h1100);
         r.horiz_distance = 24'h000200 << (i % 6);
         r.vert_distance  = (i % 2) ? r.horiz_distance : 24'h000300 << (i % 5);
         r.screen_column = 10'(i * 61);
         r.screen_row = 10'(i * 37);
         pixel_table.push_back('{r, 1'b0, '0});
      end
   endtask

   // Stimulus sequence
   initial begin
      rwct_pkg::rsp_type none_rsp;
      int random_blocks;
      none_rsp = '0;
      heading_q = '0; viewer_x_q = '0; viewer_y_q = '0; proj_dist_q = '0; art_set_q = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      build_table();
      foreach (pixel_table[i]) push_pixel(pixel_table[i].req, pixel_table[i].typed,
                                          pixel_table[i].want);
      drain();
      load_view(13'd100, 24'h018000, 24'h01C000, 24'h004000, 1'b1);
      foreach (pixel_table[i]) push_pixel(pixel_table[i].req, 1'b0, none_rsp);
      drain();

      // random phases: sender/receiver idling swapped, then none
      random_blocks = 0;
      for (int ph = 0; ph < 3; ph++) begin
         send_idle_pct = (ph == 0) ? 26 : (ph == 1) ? 84 : 0;
         recv_idle_pct = (ph == 0) ? 84 : (ph == 1) ? 26 : 0;
         for (int b = 0; b < BLOCKS; b++) begin
            case (random_blocks % 4)
               0: load_view(13'($urandom_range(5759)), 24'($urandom()), 24'($urandom()),
                            24'($urandom_range(24'h100, 24'h40000)), 1'($urandom()));
               1: load_view(13'd5759, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1'b1);
               2: load_view(13'd0, 24'd0, 24'd0, 24'd0, 1'b0);
               default: load_view(13'($urandom_range(5760, 8191)), 24'($urandom()),
                                  24'($urandom()),
                                  24'($urandom_range(24'h800, 24'h8000)), 1'($urandom()));
            endcase
            random_blocks++;
            if (ph == 2 && b == 1) hold_go <= 1'b1;
            repeat (BLOCK_ITEMS) push_pixel(rand_pixel(), 1'b0, none_rsp);
            drain();
         end
      end

      $display("Covered %0d pixel requests, %0d responses checked, across %0d views.",
               items_sent, checked, random_blocks + 2);
      $display("Idling swapped between sides, one long response hold-off, drains between views.");
      if (errors == 0 && texel_q.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   // Watchdog
   initial begin
      #(12 * 1000000);
      $display("TEST FAILED");
      $finish;
   end

endmodule

// ----- raycast_wall_column_texel.f -----
design/rwct_pkg.sv
design/rwct_cos.sv
design/rwct_div.sv
design/raycast_wall_column_texel.sv
dv/tb_top.sv
